FILE: rtl/core/vcpd_pkg.sv
// ----------------------------------------------------------------------------
// vcpd_pkg
// Shared constants, register and command codes and transfer types for the
// vehicle corner path deviation check unit.
// ----------------------------------------------------------------------------
package vcpd_pkg;

    localparam int PATH_DEPTH = 4096;
    localparam int PATH_AW    = (PATH_DEPTH > 1) ? $clog2(PATH_DEPTH) : 1;
    localparam int CNT_W      = $clog2(PATH_DEPTH + 1);

    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_FRONT_OFFSET    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REAR_OFFSET     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LEFT_OFFSET     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RIGHT_OFFSET    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FRONT_THRESHOLD = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_RR_THRESHOLD    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_RL_THRESHOLD    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SEARCH_RADIUS   = 3'd7;

    localparam logic [CFG_W-1:0] RST_FRONT_OFFSET    = 16'd1102;
    localparam logic [CFG_W-1:0] RST_REAR_OFFSET     = 16'd690;
    localparam logic [CFG_W-1:0] RST_LEFT_OFFSET     = 16'd310;
    localparam logic [CFG_W-1:0] RST_RIGHT_OFFSET    = 16'd310;
    localparam logic [CFG_W-1:0] RST_FRONT_THRESHOLD = 16'd435;
    localparam logic [CFG_W-1:0] RST_RR_THRESHOLD    = 16'd884;
    localparam logic [CFG_W-1:0] RST_RL_THRESHOLD    = 16'd884;
    localparam logic [CFG_W-1:0] RST_SEARCH_RADIUS   = 16'd25600;

    localparam logic [1:0] CMD_CLEAR  = 2'd0;
    localparam logic [1:0] CMD_APPEND = 2'd1;
    localparam logic [1:0] CMD_CHECK  = 2'd2;

    // product slots of the shared multiplier
    localparam int NUM_PRODUCTS = 12;
    localparam logic [3:0] PRD_FC  = 4'd0;
    localparam logic [3:0] PRD_FS  = 4'd1;
    localparam logic [3:0] PRD_LS  = 4'd2;
    localparam logic [3:0] PRD_LC  = 4'd3;
    localparam logic [3:0] PRD_RS  = 4'd4;
    localparam logic [3:0] PRD_RC  = 4'd5;
    localparam logic [3:0] PRD_BC  = 4'd6;
    localparam logic [3:0] PRD_BS  = 4'd7;
    localparam logic [3:0] PRD_TF  = 4'd8;
    localparam logic [3:0] PRD_TRR = 4'd9;
    localparam logic [3:0] PRD_TRL = 4'd10;
    localparam logic [3:0] PRD_RAD = 4'd11;

    localparam int PROD_W = 34;
    localparam int SUM_W  = 36;
    localparam int OFF_W  = 21;
    localparam int CRN_W  = 25;
    localparam int DIF_W  = 26;
    localparam int SQ_W   = 50;
    localparam int DST_W  = 51;

    typedef struct packed {
        logic [1:0]         command;
        logic signed [23:0] x_coord;
        logic signed [23:0] y_coord;
        logic signed [15:0] cos_yaw;
        logic signed [15:0] sin_yaw;
    } request_t;

    typedef struct packed {
        logic       out_of_path;
        logic [3:0] corner_out_flags;
        logic       path_empty;
        logic       path_overflowed;
    } result_t;

endpackage

FILE: rtl/core/vehicle_corner_path_deviation_check_unit.sv
// ----------------------------------------------------------------------------
// vehicle_corner_path_deviation_check_unit
// Stores a planned path and checks the four footprint corners of a pose
// against it through one shared multiplier and a four-lane distance scan.
// ----------------------------------------------------------------------------
//  channel   signals                          transfer
//  request   start, busy, request             start high and busy low
//  result    done, result                     done high, one cycle, no stall
//  config    cfg_wr_en, cfg_index, cfg_wdata  cfg_wr_en high
//
//  Clear, append and unused commands complete while busy stays low.
//  A check holds busy through twelve passes of the shared 17x17 multiplier,
//  then one path memory read per point through the single read port, then
//  the four-lane pipeline drain. done and the result show in the cycle busy
//  falls.
//  Reset clears the path count and overflow mark and restores config defaults.
//  The result receiver cannot stall; busy holds off new requests.
// ----------------------------------------------------------------------------
module vehicle_corner_path_deviation_check_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  vcpd_pkg::request_t                  request,
    output logic                                done,
    output vcpd_pkg::result_t                   result,
    input  logic                                cfg_wr_en,
    input  logic [vcpd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [vcpd_pkg::CFG_W-1:0]          cfg_wdata
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_MUL    = 3'd1;
    localparam logic [2:0] ST_SUM    = 3'd2;
    localparam logic [2:0] ST_CORNER = 3'd3;
    localparam logic [2:0] ST_SCAN   = 3'd4;
    localparam logic [2:0] ST_DRAIN  = 3'd5;
    localparam logic [2:0] ST_FINISH = 3'd6;

    localparam int AW  = vcpd_pkg::PATH_AW;
    localparam int CW  = vcpd_pkg::CNT_W;
    localparam int PW  = vcpd_pkg::PROD_W;
    localparam int SW  = vcpd_pkg::SUM_W;
    localparam int OW  = vcpd_pkg::OFF_W;
    localparam int KW  = vcpd_pkg::CRN_W;
    localparam int DW  = vcpd_pkg::DIF_W;
    localparam int QW  = vcpd_pkg::SQ_W;
    localparam int TW  = vcpd_pkg::DST_W;

    localparam logic signed [SW-1:0] ROUND_BIAS = 36'sd8192;

    // configuration
    logic [vcpd_pkg::CFG_W-1:0] front_offset_reg;
    logic [vcpd_pkg::CFG_W-1:0] rear_offset_reg;
    logic [vcpd_pkg::CFG_W-1:0] left_offset_reg;
    logic [vcpd_pkg::CFG_W-1:0] right_offset_reg;
    logic [vcpd_pkg::CFG_W-1:0] front_thr_reg;
    logic [vcpd_pkg::CFG_W-1:0] rr_thr_reg;
    logic [vcpd_pkg::CFG_W-1:0] rl_thr_reg;
    logic [vcpd_pkg::CFG_W-1:0] radius_reg;

    // control
    logic [2:0]    state_reg, state_next;
    logic [3:0]    step_reg, step_next;
    logic [CW-1:0] count_reg, count_next;
    logic          overflow_reg, overflow_next;
    logic [CW-1:0] addr_reg, addr_next;
    logic [3:0]    pipe_v_reg, pipe_v_next;
    logic          done_reg, done_next;

    logic accept;
    logic issue;
    logic has_room;
    logic mem_we;

    // datapath
    logic signed [23:0]  x_reg, y_reg;
    logic signed [15:0]  cos_reg, sin_reg;
    logic signed [PW-1:0] prod_reg [vcpd_pkg::NUM_PRODUCTS];
    logic signed [OW-1:0] off_reg [8];
    logic signed [KW-1:0] cx_reg [4];
    logic signed [KW-1:0] cy_reg [4];
    logic signed [DW-1:0] dx_reg [4];
    logic signed [DW-1:0] dy_reg [4];
    logic [QW-1:0]        sqx_reg [4];
    logic [QW-1:0]        sqy_reg [4];
    logic [TW-1:0]        dist_reg [4];
    logic [TW-1:0]        best_reg [4];
    vcpd_pkg::result_t    result_reg;

    logic [47:0] path_mem [vcpd_pkg::PATH_DEPTH];
    logic [47:0] mem_q_reg;

    logic signed [16:0]   op_a, op_b;
    logic signed [PW-1:0] mul_p;
    logic signed [SW-1:0] sum_val [8];
    logic signed [SW-1:0] shf_val [8];
    logic signed [51:0]   sqx_full [4];
    logic signed [51:0]   sqy_full [4];
    logic [TW-1:0]        thr2 [4];
    logic [TW-1:0]        rad2;
    logic [3:0]           flags;

    assign busy     = (state_reg != ST_IDLE);
    assign accept   = start && !busy;
    assign has_room = (count_reg < CW'(vcpd_pkg::PATH_DEPTH));
    assign mem_we   = accept && (request.command == vcpd_pkg::CMD_APPEND) && has_room;
    assign issue    = (state_reg == ST_SCAN) && (addr_reg < count_reg);
    assign done     = done_reg;
    assign result   = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_offset_reg <= vcpd_pkg::RST_FRONT_OFFSET;
            rear_offset_reg  <= vcpd_pkg::RST_REAR_OFFSET;
            left_offset_reg  <= vcpd_pkg::RST_LEFT_OFFSET;
            right_offset_reg <= vcpd_pkg::RST_RIGHT_OFFSET;
            front_thr_reg    <= vcpd_pkg::RST_FRONT_THRESHOLD;
            rr_thr_reg       <= vcpd_pkg::RST_RR_THRESHOLD;
            rl_thr_reg       <= vcpd_pkg::RST_RL_THRESHOLD;
            radius_reg       <= vcpd_pkg::RST_SEARCH_RADIUS;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                vcpd_pkg::REG_FRONT_OFFSET:    front_offset_reg <= cfg_wdata;
                vcpd_pkg::REG_REAR_OFFSET:     rear_offset_reg  <= cfg_wdata;
                vcpd_pkg::REG_LEFT_OFFSET:     left_offset_reg  <= cfg_wdata;
                vcpd_pkg::REG_RIGHT_OFFSET:    right_offset_reg <= cfg_wdata;
                vcpd_pkg::REG_FRONT_THRESHOLD: front_thr_reg    <= cfg_wdata;
                vcpd_pkg::REG_RR_THRESHOLD:    rr_thr_reg       <= cfg_wdata;
                vcpd_pkg::REG_RL_THRESHOLD:    rl_thr_reg       <= cfg_wdata;
                vcpd_pkg::REG_SEARCH_RADIUS:   radius_reg       <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        step_next     = step_reg;
        count_next    = count_reg;
        overflow_next = overflow_reg;
        addr_next     = addr_reg;
        done_next     = 1'b0;
        pipe_v_next   = {pipe_v_reg[2:0], issue};
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (request.command)
                        vcpd_pkg::CMD_CLEAR:
                        begin
                            count_next    = '0;
                            overflow_next = 1'b0;
                        end
                        vcpd_pkg::CMD_APPEND:
                        begin
                            if (has_room)
                            begin
                                count_next = count_reg + CW'(1);
                            end
                            else
                            begin
                                overflow_next = 1'b1;
                            end
                        end
                        vcpd_pkg::CMD_CHECK:
                        begin
                            state_next = ST_MUL;
                            step_next  = '0;
                        end
                        default: ;
                    endcase
                end
            end
            ST_MUL:
            begin
                step_next = step_reg + 4'd1;
                if (step_reg == 4'(vcpd_pkg::NUM_PRODUCTS - 1))
                begin
                    state_next = ST_SUM;
                end
            end
            ST_SUM:
            begin
                state_next = ST_CORNER;
            end
            ST_CORNER:
            begin
                state_next = ST_SCAN;
                addr_next  = '0;
            end
            ST_SCAN:
            begin
                if (issue)
                begin
                    addr_next = addr_reg + CW'(1);
                end
                else
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (pipe_v_reg == 4'd0)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                state_next = ST_IDLE;
                done_next  = 1'b1;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            step_reg     <= '0;
            count_reg    <= '0;
            overflow_reg <= 1'b0;
            addr_reg     <= '0;
            pipe_v_reg   <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            step_reg     <= step_next;
            count_reg    <= count_next;
            overflow_reg <= overflow_next;
            addr_reg     <= addr_next;
            pipe_v_reg   <= pipe_v_next;
            done_reg     <= done_next;
        end
    end

    // path memory
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            path_mem[count_reg[AW-1:0]] <= {request.x_coord, request.y_coord};
        end
        if (issue)
        begin
            mem_q_reg <= path_mem[addr_reg[AW-1:0]];
        end
    end

    // shared multiplier operand select
    always_comb
    begin
        op_a = '0;
        op_b = '0;
        case (step_reg)
            vcpd_pkg::PRD_FC:
            begin
                op_a = $signed({1'b0, front_offset_reg});
                op_b = 17'(cos_reg);
            end
            vcpd_pkg::PRD_FS:
            begin
                op_a = $signed({1'b0, front_offset_reg});
                op_b = 17'(sin_reg);
            end
            vcpd_pkg::PRD_LS:
            begin
                op_a = $signed({1'b0, left_offset_reg});
                op_b = 17'(sin_reg);
            end
            vcpd_pkg::PRD_LC:
            begin
                op_a = $signed({1'b0, left_offset_reg});
                op_b = 17'(cos_reg);
            end
            vcpd_pkg::PRD_RS:
            begin
                op_a = $signed({1'b0, right_offset_reg});
                op_b = 17'(sin_reg);
            end
            vcpd_pkg::PRD_RC:
            begin
                op_a = $signed({1'b0, right_offset_reg});
                op_b = 17'(cos_reg);
            end
            vcpd_pkg::PRD_BC:
            begin
                op_a = $signed({1'b0, rear_offset_reg});
                op_b = 17'(cos_reg);
            end
            vcpd_pkg::PRD_BS:
            begin
                op_a = $signed({1'b0, rear_offset_reg});
                op_b = 17'(sin_reg);
            end
            vcpd_pkg::PRD_TF:
            begin
                op_a = $signed({1'b0, front_thr_reg});
                op_b = $signed({1'b0, front_thr_reg});
            end
            vcpd_pkg::PRD_TRR:
            begin
                op_a = $signed({1'b0, rr_thr_reg});
                op_b = $signed({1'b0, rr_thr_reg});
            end
            vcpd_pkg::PRD_TRL:
            begin
                op_a = $signed({1'b0, rl_thr_reg});
                op_b = $signed({1'b0, rl_thr_reg});
            end
            vcpd_pkg::PRD_RAD:
            begin
                op_a = $signed({1'b0, radius_reg});
                op_b = $signed({1'b0, radius_reg});
            end
            default: ;
        endcase
    end

    assign mul_p = op_a * op_b;

    // corner offsets, round to nearest with ties up
    always_comb
    begin
        sum_val[0] = SW'(prod_reg[vcpd_pkg::PRD_FC]) - SW'(prod_reg[vcpd_pkg::PRD_LS]);
        sum_val[1] = SW'(prod_reg[vcpd_pkg::PRD_FS]) + SW'(prod_reg[vcpd_pkg::PRD_LC]);
        sum_val[2] = SW'(prod_reg[vcpd_pkg::PRD_FC]) + SW'(prod_reg[vcpd_pkg::PRD_RS]);
        sum_val[3] = SW'(prod_reg[vcpd_pkg::PRD_FS]) - SW'(prod_reg[vcpd_pkg::PRD_RC]);
        sum_val[4] = SW'(prod_reg[vcpd_pkg::PRD_RS]) - SW'(prod_reg[vcpd_pkg::PRD_BC]);
        sum_val[5] = -SW'(prod_reg[vcpd_pkg::PRD_BS]) - SW'(prod_reg[vcpd_pkg::PRD_RC]);
        sum_val[6] = -SW'(prod_reg[vcpd_pkg::PRD_BC]) - SW'(prod_reg[vcpd_pkg::PRD_LS]);
        sum_val[7] = SW'(prod_reg[vcpd_pkg::PRD_LC]) - SW'(prod_reg[vcpd_pkg::PRD_BS]);
        for (int i = 0; i < 8; i++)
        begin
            shf_val[i] = (sum_val[i] + ROUND_BIAS) >>> 14;
        end
    end

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            sqx_full[k] = dx_reg[k] * dx_reg[k];
            sqy_full[k] = dy_reg[k] * dy_reg[k];
        end
    end

    assign thr2[0] = TW'(prod_reg[vcpd_pkg::PRD_TF][31:0]);
    assign thr2[1] = TW'(prod_reg[vcpd_pkg::PRD_TF][31:0]);
    assign thr2[2] = TW'(prod_reg[vcpd_pkg::PRD_TRR][31:0]);
    assign thr2[3] = TW'(prod_reg[vcpd_pkg::PRD_TRL][31:0]);
    assign rad2    = TW'(prod_reg[vcpd_pkg::PRD_RAD][31:0]);

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            flags[k] = (count_reg != '0) && (best_reg[k] < rad2) && (best_reg[k] > thr2[k]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && (request.command == vcpd_pkg::CMD_CHECK))
        begin
            x_reg   <= request.x_coord;
            y_reg   <= request.y_coord;
            cos_reg <= request.cos_yaw;
            sin_reg <= request.sin_yaw;
        end
        if (state_reg == ST_MUL)
        begin
            prod_reg[step_reg] <= mul_p;
        end
        if (state_reg == ST_SUM)
        begin
            for (int i = 0; i < 8; i++)
            begin
                off_reg[i] <= shf_val[i][OW-1:0];
            end
        end
        if (state_reg == ST_CORNER)
        begin
            for (int k = 0; k < 4; k++)
            begin
                cx_reg[k]   <= KW'(x_reg) + KW'(off_reg[2*k]);
                cy_reg[k]   <= KW'(y_reg) + KW'(off_reg[2*k+1]);
                best_reg[k] <= '1;
            end
        end
        for (int k = 0; k < 4; k++)
        begin
            if (pipe_v_reg[0])
            begin
                dx_reg[k] <= DW'(cx_reg[k]) - DW'($signed(mem_q_reg[47:24]));
                dy_reg[k] <= DW'(cy_reg[k]) - DW'($signed(mem_q_reg[23:0]));
            end
            if (pipe_v_reg[1])
            begin
                sqx_reg[k] <= sqx_full[k][QW-1:0];
                sqy_reg[k] <= sqy_full[k][QW-1:0];
            end
            if (pipe_v_reg[2])
            begin
                dist_reg[k] <= TW'(sqx_reg[k]) + TW'(sqy_reg[k]);
            end
            if (pipe_v_reg[3] && (dist_reg[k] < best_reg[k]))
            begin
                best_reg[k] <= dist_reg[k];
            end
        end
        if (state_reg == ST_FINISH)
        begin
            result_reg.out_of_path      <= (flags != 4'd0);
            result_reg.corner_out_flags <= flags;
            result_reg.path_empty       <= (count_reg == '0);
            result_reg.path_overflowed  <= overflow_reg;
        end
    end

endmodule

FILE: rtl/core/vcpd_checker.sv
// ----------------------------------------------------------------------------
// vcpd_checker
// Port-level checks for the vehicle corner path deviation check unit.
// ----------------------------------------------------------------------------
module vcpd_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                start,
    input logic                                busy,
    input vcpd_pkg::request_t                  request,
    input logic                                done,
    input vcpd_pkg::result_t                   result,
    input logic                                cfg_wr_en,
    input logic [vcpd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input logic [vcpd_pkg::CFG_W-1:0]          cfg_wdata
);

    logic check_start;

    assign check_start = start && !busy && (request.command == vcpd_pkg::CMD_CHECK);

    a_check_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
        check_start |=> busy)
        else $error("check transfer did not raise busy");

    a_done_ends_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("busy dropped without a result");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

    a_summary_flag: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.out_of_path == (result.corner_out_flags != 4'd0)))
        else $error("out_of_path disagrees with corner flags");

    a_empty_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.path_empty) |-> (result.corner_out_flags == 4'd0))
        else $error("empty path flagged a corner");

endmodule

bind vehicle_corner_path_deviation_check_unit vcpd_checker u_vcpd_checker (.*);

FILE: tb/vehicle_corner_path_deviation_check_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// vehicle_corner_path_deviation_check_unit_tb
// Loads short planned paths and checks vehicle poses against them under
// several register settings. A scoreboard recomputes the four footprint
// corners and their nearest path distances for every accepted check and
// compares each result as it comes.
// ----------------------------------------------------------------------------
module vehicle_corner_path_deviation_check_unit_tb;

    import vcpd_pkg::*;

    localparam logic [1:0] CMD_UNUSED   = 2'd3;
    localparam int         DRAIN_CYCLES = 40;
    localparam int         BASE_SPAN    = 8000000;

    logic                 clk;
    logic                 rst_n     = 1'b0;
    logic                 start     = 1'b0;
    logic                 busy;
    request_t             request   = '0;
    logic                 done;
    result_t              result;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_wdata = '0;

    request_t   pending_requests[$];
    result_t    expected_results[$];
    int         path_xs [PATH_DEPTH];
    int         path_ys [PATH_DEPTH];
    int         stored_points;
    logic       drop_seen;
    logic [CFG_W-1:0] cfg_regs [8];
    int         sender_idle_pct;
    int         est_points;
    int         mismatches = 0;
    int         check_count = 0;

    vehicle_corner_path_deviation_check_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .request   (request),
        .done      (done),
        .result    (result),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #4000000;
        $display("vehicle_corner_path_deviation_check_unit_tb failed");
        $finish;
    end

    function automatic longint round_q14(input longint v);
        return (v + 64'sd8192) >>> 14;
    endfunction

    function automatic int rand_in(input int span);
        return int'($urandom_range(2 * span)) - span;
    endfunction

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $time, what);
        mismatches++;
    endtask

    task automatic apply_request(input request_t rq);
        result_t res;
        logic [3:0] flags;
        longint px, py, c, s, f, b, l, r, dx, dy, d, rad2;
        longint cx [4];
        longint cy [4];
        longint best [4];
        longint lim2 [4];
        case (rq.command)
            CMD_CLEAR:
            begin
                stored_points = 0;
                drop_seen     = 1'b0;
            end
            CMD_APPEND:
            begin
                if (stored_points < PATH_DEPTH)
                begin
                    path_xs[stored_points] = int'(signed'(rq.x_coord));
                    path_ys[stored_points] = int'(signed'(rq.y_coord));
                    stored_points++;
                end
                else
                begin
                    drop_seen = 1'b1;
                end
            end
            CMD_CHECK:
            begin
                px = longint'(signed'(rq.x_coord));
                py = longint'(signed'(rq.y_coord));
                c  = longint'(signed'(rq.cos_yaw));
                s  = longint'(signed'(rq.sin_yaw));
                f  = longint'(cfg_regs[REG_FRONT_OFFSET]);
                b  = longint'(cfg_regs[REG_REAR_OFFSET]);
                l  = longint'(cfg_regs[REG_LEFT_OFFSET]);
                r  = longint'(cfg_regs[REG_RIGHT_OFFSET]);
                cx[0] = px + round_q14(f * c - l * s);
                cy[0] = py + round_q14(f * s + l * c);
                cx[1] = px + round_q14(f * c + r * s);
                cy[1] = py + round_q14(f * s - r * c);
                cx[2] = px + round_q14(-b * c + r * s);
                cy[2] = py + round_q14(-b * s - r * c);
                cx[3] = px + round_q14(-b * c - l * s);
                cy[3] = py + round_q14(-b * s + l * c);
                lim2[0] = longint'(cfg_regs[REG_FRONT_THRESHOLD]) *
                          longint'(cfg_regs[REG_FRONT_THRESHOLD]);
                lim2[1] = lim2[0];
                lim2[2] = longint'(cfg_regs[REG_RR_THRESHOLD]) *
                          longint'(cfg_regs[REG_RR_THRESHOLD]);
                lim2[3] = longint'(cfg_regs[REG_RL_THRESHOLD]) *
                          longint'(cfg_regs[REG_RL_THRESHOLD]);
                rad2 = longint'(cfg_regs[REG_SEARCH_RADIUS]) *
                       longint'(cfg_regs[REG_SEARCH_RADIUS]);
                flags = '0;
                for (int k = 0; k < 4; k++)
                    best[k] = 64'sh7FFF_FFFF_FFFF_FFFF;
                for (int i = 0; i < stored_points; i++)
                begin
                    for (int k = 0; k < 4; k++)
                    begin
                        dx = cx[k] - longint'(path_xs[i]);
                        dy = cy[k] - longint'(path_ys[i]);
                        d  = dx * dx + dy * dy;
                        if (d < best[k])
                            best[k] = d;
                    end
                end
                for (int k = 0; k < 4; k++)
                begin
                    if (stored_points != 0 && best[k] < rad2 && best[k] > lim2[k])
                        flags[k] = 1'b1;
                end
                res.out_of_path      = |flags;
                res.corner_out_flags = flags;
                res.path_empty       = (stored_points == 0);
                res.path_overflowed  = drop_seen;
                expected_results = {expected_results, res};
            end
            default:
            begin
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else
        begin
            if (start && !busy)
            begin
                apply_request(request);
                void'(pending_requests.pop_front());
            end
            if (pending_requests.size() != 0 && $urandom_range(99) >= sender_idle_pct)
            begin
                start   <= 1'b1;
                request <= pending_requests[0];
            end
            else
            begin
                start <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && done)
        begin
            check_count++;
            if (expected_results.size() == 0)
            begin
                report_mismatch($sformatf("result %0d arrived with none expected",
                                          check_count));
            end
            else
            begin
                want = expected_results.pop_front();
                if (result.out_of_path !== want.out_of_path ||
                    result.corner_out_flags !== want.corner_out_flags ||
                    result.path_empty !== want.path_empty ||
                    result.path_overflowed !== want.path_overflowed)
                    report_mismatch($sformatf(
                        "result %0d got oop=%b flags=%b empty=%b ovf=%b, want %b %b %b %b",
                        check_count, result.out_of_path, result.corner_out_flags,
                        result.path_empty, result.path_overflowed, want.out_of_path,
                        want.corner_out_flags, want.path_empty, want.path_overflowed));
            end
        end
    end

    task automatic queue_item(input logic [1:0] cmd, input int x, input int y,
                              input int c, input int s);
        request_t rq;
        rq.command = cmd;
        rq.x_coord = 24'(x);
        rq.y_coord = 24'(y);
        rq.cos_yaw = 16'(c);
        rq.sin_yaw = 16'(s);
        pending_requests = {pending_requests, rq};
    endtask

    task automatic make_yaw(output int c, output int s);
        real ang;
        int  pick;
        pick = $urandom_range(9);
        if (pick == 0)
        begin
            c = rand_in(32767);
            s = rand_in(32767);
        end
        else if (pick == 1)
        begin
            case ($urandom_range(3))
                0: begin c = 16384;  s = 0;      end
                1: begin c = 0;      s = 16384;  end
                2: begin c = -16384; s = 0;      end
                default: begin c = 0; s = -16384; end
            endcase
        end
        else
        begin
            ang = real'($urandom_range(35999)) * 3.14159265358979 / 18000.0;
            c = $rtoi($cos(ang) * 16384.0);
            s = $rtoi($sin(ang) * 16384.0);
        end
    endtask

    task automatic add_random_items(input int n);
        int added, spread, bx, by, c, s, cnt, widest;
        logic [31:0] bits;
        logic [1:0]  cmd;
        added  = 0;
        widest = 0;
        for (int i = 0; i < 4; i++)
            if (int'(cfg_regs[i]) > widest)
                widest = int'(cfg_regs[i]);
        spread = 2000 + 2 * widest;
        while (added < n)
        begin
            if ($urandom_range(99) < 12)
            begin
                cmd  = 2'($urandom_range(3));
                bits = $urandom();
                queue_item(cmd, int'(signed'(bits[23:0])), int'(signed'(24'($urandom()))),
                           int'(signed'(bits[31:16])), int'(signed'(16'($urandom()))));
                if (cmd != CMD_UNUSED)
                    added++;
                if (cmd == CMD_CLEAR)
                    est_points = 0;
                else if (cmd == CMD_APPEND)
                    est_points++;
            end
            else
            begin
                if (est_points > 40 || $urandom_range(3) == 0)
                begin
                    queue_item(CMD_CLEAR, rand_in(BASE_SPAN), rand_in(BASE_SPAN), 0, 0);
                    est_points = 0;
                    added++;
                end
                bx  = rand_in(BASE_SPAN);
                by  = rand_in(BASE_SPAN);
                cnt = $urandom_range(1, 10);
                for (int i = 0; i < cnt; i++)
                    queue_item(CMD_APPEND, bx + rand_in(spread), by + rand_in(spread),
                               rand_in(32767), rand_in(32767));
                est_points += cnt;
                added      += cnt;
                cnt = $urandom_range(1, 3);
                for (int i = 0; i < cnt; i++)
                begin
                    make_yaw(c, s);
                    queue_item(CMD_CHECK, bx + rand_in(spread / 2), by + rand_in(spread / 2),
                               c, s);
                end
                added += cnt;
            end
        end
    endtask

    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        cfg_regs[idx] = val;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic settle();
        while (pending_requests.size() != 0 || expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        cfg_regs[REG_FRONT_OFFSET]    = RST_FRONT_OFFSET;
        cfg_regs[REG_REAR_OFFSET]     = RST_REAR_OFFSET;
        cfg_regs[REG_LEFT_OFFSET]     = RST_LEFT_OFFSET;
        cfg_regs[REG_RIGHT_OFFSET]    = RST_RIGHT_OFFSET;
        cfg_regs[REG_FRONT_THRESHOLD] = RST_FRONT_THRESHOLD;
        cfg_regs[REG_RR_THRESHOLD]    = RST_RR_THRESHOLD;
        cfg_regs[REG_RL_THRESHOLD]    = RST_RL_THRESHOLD;
        cfg_regs[REG_SEARCH_RADIUS]   = RST_SEARCH_RADIUS;
        stored_points   = 0;
        drop_seen       = 1'b0;
        est_points      = 0;
        sender_idle_pct = 6;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: empty path, unused code, extreme points and poses
        queue_item(CMD_CHECK, 0, 0, 16384, 0);
        queue_item(CMD_UNUSED, -1, -1, -1, -1);
        queue_item(CMD_APPEND, -8388608, -8388608, 0, 0);
        queue_item(CMD_APPEND, 8388607, 8388607, 0, 0);
        queue_item(CMD_APPEND, -8388608, 8388607, 0, 0);
        queue_item(CMD_APPEND, 8388607, -8388608, 0, 0);
        queue_item(CMD_CHECK, 8388607, 8388607, -32768, 32767);
        queue_item(CMD_CHECK, -8388608, -8388608, 32767, -32768);
        queue_item(CMD_CLEAR, 0, 0, 0, 0);
        queue_item(CMD_CHECK, 0, 0, 16384, 0);
        for (int i = 0; i < 6; i++)
            queue_item(CMD_APPEND, 256 * i, 40 * i, 0, 0);
        queue_item(CMD_CHECK, 0, 0, 16384, 0);
        queue_item(CMD_CHECK, 300, 0, 0, 16384);
        queue_item(CMD_CHECK, 600, 100, -16384, 0);
        queue_item(CMD_CHECK, 900, -100, 11585, 11585);
        add_random_items(20);
        settle();

        // small offsets: search radius boundary and rounding ties
        set_reg(REG_FRONT_OFFSET, 16'd1);
        set_reg(REG_REAR_OFFSET, 16'd0);
        set_reg(REG_LEFT_OFFSET, 16'd0);
        set_reg(REG_RIGHT_OFFSET, 16'd0);
        set_reg(REG_FRONT_THRESHOLD, 16'd100);
        set_reg(REG_RR_THRESHOLD, 16'd100);
        set_reg(REG_RL_THRESHOLD, 16'd100);
        set_reg(REG_SEARCH_RADIUS, 16'd1000);
        queue_item(CMD_CLEAR, 0, 0, 0, 0);
        queue_item(CMD_APPEND, 1000, 0, 0, 0);
        queue_item(CMD_CHECK, 0, 0, 16384, 0);
        queue_item(CMD_CHECK, 0, 0, 8192, 0);
        queue_item(CMD_CHECK, 0, 0, -8192, 0);
        queue_item(CMD_CLEAR, 0, 0, 0, 0);
        queue_item(CMD_APPEND, 0, 100, 0, 0);
        queue_item(CMD_CHECK, 0, 0, 16384, 0);
        add_random_items(15);
        settle();

        sender_idle_pct = 74;
        for (int i = 0; i < 4; i++)
            set_reg(3'(i), 16'hFFFF);
        set_reg(REG_FRONT_THRESHOLD, 16'd0);
        set_reg(REG_RR_THRESHOLD, 16'd0);
        set_reg(REG_RL_THRESHOLD, 16'd0);
        set_reg(REG_SEARCH_RADIUS, 16'hFFFF);
        add_random_items(20);
        settle();

        for (int i = 0; i < 4; i++)
            set_reg(3'(i), 16'($urandom_range(3000)));
        set_reg(REG_FRONT_THRESHOLD, 16'd40000);
        set_reg(REG_RR_THRESHOLD, 16'hFFFF);
        set_reg(REG_RL_THRESHOLD, 16'd300);
        set_reg(REG_SEARCH_RADIUS, 16'd40000);
        add_random_items(15);
        settle();

        sender_idle_pct = 0;
        set_reg(REG_SEARCH_RADIUS, 16'd0);
        set_reg(REG_RR_THRESHOLD, 16'd500);
        add_random_items(15);
        settle();

        for (int i = 0; i < 4; i++)
            set_reg(3'(i), 16'($urandom_range(2000)));
        set_reg(REG_FRONT_THRESHOLD, 16'($urandom_range(1500)));
        set_reg(REG_RR_THRESHOLD, 16'($urandom_range(1500)));
        set_reg(REG_RL_THRESHOLD, 16'($urandom_range(1500)));
        set_reg(REG_SEARCH_RADIUS, 16'($urandom_range(1000, 20000)));
        add_random_items(20);
        settle();

        if (mismatches == 0)
            $display("vehicle_corner_path_deviation_check_unit_tb passed");
        else
            $display("vehicle_corner_path_deviation_check_unit_tb failed");
        $finish;
    end

endmodule
